@@ rtl/yabd_pkg.sv @@
// Shared types and constants for the anchor box decode block.
// No dependencies.
`timescale 1ns / 1ps
package yabd_pkg;

	typedef logic [16:0] sig_t;     // Q0.16 in [0, 65536]
	typedef logic [9:0]  px_t;      // anchor size in pixels

	typedef enum logic [1:0] {
		REG_SCORE_THRESHOLD = 2'd0,
		REG_FRAME_WIDTH     = 2'd1,
		REG_FRAME_HEIGHT    = 2'd2
	} reg_idx_t;

	localparam logic [15:0] SCORE_THRESHOLD_RST = 16'd55706;
	localparam logic [11:0] FRAME_WIDTH_RST     = 12'd448;
	localparam logic [11:0] FRAME_HEIGHT_RST    = 12'd256;

	localparam logic [1:0] LAST_ANCHOR = 2'd2;

	// anchor sizes per head (stride 8, 16, 32, 64) and anchor
	localparam px_t ANCHOR_W [4][3] = '{
		'{10'd19,  10'd44,  10'd38},
		'{10'd96,  10'd86,  10'd180},
		'{10'd140, 10'd303, 10'd238},
		'{10'd436, 10'd739, 10'd925}
	};
	localparam px_t ANCHOR_H [4][3] = '{
		'{10'd27,  10'd40,  10'd94},
		'{10'd68,  10'd152, 10'd137},
		'{10'd301, 10'd264, 10'd542},
		'{10'd615, 10'd380, 10'd792}
	};

endpackage

@@ rtl/yabd_sigmoid.sv @@
// Piecewise linear sigmoid, signed fixed-point logit in, Q0.16 out.
// Depends on yabd_pkg.
`timescale 1ns / 1ps
module yabd_sigmoid
	import yabd_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic signed [15:0] x,
	output sig_t               y
);

	localparam int SH = 16 - FRAC_BITS;

	logic        neg;
	logic [16:0] mag17;
	logic [28:0] mag;
	sig_t        pos;

	always_comb begin
		neg   = x[15];
		mag17 = neg ? 17'(-$signed({x[15], x})) : {1'b0, x};
		mag   = {12'b0, mag17} << SH;
		priority if (mag >= 29'd327680) begin
			pos = 17'd65536;
		end else if (mag >= 29'd155648) begin
			pos = 17'(mag >> 5) + 17'd55296;
		end else if (mag >= 29'd65536) begin
			pos = 17'(mag >> 3) + 17'd40960;
		end else begin
			pos = 17'(mag >> 2) + 17'd32768;
		end
		y = neg ? 17'(17'd65536 - pos) : pos;
	end

endmodule

@@ rtl/yolo_anchor_box_decode_unit.sv @@
// Anchor box decode: one anchor record of a detection head in, zero or one box out.
// Depends on yabd_pkg and yabd_sigmoid.
//
// Usage:
//  Input channel in_valid/in_stall carries one anchor record per transfer: eight
//  Q8.8 logits, grid cell, head and anchor index. Output channel out_valid/out_stall
//  carries one box (edges in Q.4 pixels, class, Q0.16 score) for every record whose
//  score reaches score_threshold and whose box touches the frame; other records
//  leave no result.
//  Four register stages (sigmoids, products, anchor scaling, edges and frame test);
//  the input transfer loads the first, and out_valid is driven by the last. One
//  record is taken every cycle unless the pipeline is frozen, and the stages move as one unit.
//  When out_stall holds a waiting result, the whole pipeline freezes and in_stall is
//  raised in the same cycle; nothing is lost or repeated.
//  Reset clears all stage valid bits and loads the register defaults
//  (threshold 0.85, frame 448 x 256). Write the cfg port only while idle.
`timescale 1ns / 1ps
module yolo_anchor_box_decode_unit
	import yabd_pkg::*;
#(
	parameter int LOGIT_FRAC_BITS = 8,
	parameter int GRID_DIM_MAX    = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] center_x_logit,
	input  logic signed [15:0] center_y_logit,
	input  logic signed [15:0] width_logit,
	input  logic signed [15:0] height_logit,
	input  logic signed [15:0] objectness_logit,
	input  logic signed [15:0] class0_logit,
	input  logic signed [15:0] class1_logit,
	input  logic signed [15:0] class2_logit,
	input  logic [6:0]         cell_column,
	input  logic [6:0]         cell_row,
	input  logic [1:0]         head_index,
	input  logic [1:0]         anchor_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [18:0] box_left,
	output logic signed [18:0] box_top,
	output logic signed [18:0] box_right,
	output logic signed [18:0] box_bottom,
	output logic [1:0]         top_class,
	output logic [15:0]        score
);

	localparam int CELL_W = $clog2(GRID_DIM_MAX);

	// configuration
	logic [15:0] thr_q;
	logic [11:0] fw_q, fh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= SCORE_THRESHOLD_RST;
			fw_q  <= FRAME_WIDTH_RST;
			fh_q  <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCORE_THRESHOLD: thr_q <= cfg_data;
				REG_FRAME_WIDTH:     fw_q  <= cfg_data[11:0];
				REG_FRAME_HEIGHT:    fh_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: class pick and sigmoids
	logic signed [15:0] best;
	logic [1:0]         best_id;
	sig_t sx, sy, sw, sh, so, sc;

	always_comb begin
		best    = class0_logit;
		best_id = 2'd0;
		if (class1_logit > best) begin
			best    = class1_logit;
			best_id = 2'd1;
		end
		if (class2_logit > best) begin
			best    = class2_logit;
			best_id = 2'd2;
		end
	end

	yabd_sigmoid #(.FRAC_BITS(LOGIT_FRAC_BITS)) u_sx (.x(center_x_logit),   .y(sx));
	yabd_sigmoid #(.FRAC_BITS(LOGIT_FRAC_BITS)) u_sy (.x(center_y_logit),   .y(sy));
	yabd_sigmoid #(.FRAC_BITS(LOGIT_FRAC_BITS)) u_sw (.x(width_logit),      .y(sw));
	yabd_sigmoid #(.FRAC_BITS(LOGIT_FRAC_BITS)) u_sh (.x(height_logit),     .y(sh));
	yabd_sigmoid #(.FRAC_BITS(LOGIT_FRAC_BITS)) u_so (.x(objectness_logit), .y(so));
	yabd_sigmoid #(.FRAC_BITS(LOGIT_FRAC_BITS)) u_sc (.x(best),             .y(sc));

	logic [CELL_W-1:0] col_c, row_c;
	always_comb begin
		col_c = ({25'b0, cell_column} >= 32'(GRID_DIM_MAX)) ?
			CELL_W'(GRID_DIM_MAX - 1) : CELL_W'(cell_column);
		row_c = ({25'b0, cell_row} >= 32'(GRID_DIM_MAX)) ?
			CELL_W'(GRID_DIM_MAX - 1) : CELL_W'(cell_row);
	end

	logic              v_s1;
	sig_t              sx_s1, sy_s1, sw_s1, sh_s1, so_s1, sc_s1;
	logic [1:0]        id_s1, head_s1, anc_s1;
	logic [CELL_W-1:0] col_s1, row_s1;

	// stage 2: score product, squares, centers, anchor lookup
	logic              v_s2;
	logic [16:0]       prob_s2;
	logic [32:0]       sqw_s2, sqh_s2;
	logic signed [23:0] cx_s2, cy_s2;
	px_t               aw_s2, ah_s2;
	logic [1:0]        id_s2;

	logic [33:0]        prod;
	logic signed [26:0] tx, ty;
	always_comb begin
		prod = 34'(so_s1) * 34'(sc_s1);
		tx = $signed({9'b0, sx_s1, 1'b0}) - 27'sd32768 + $signed(27'(col_s1) << 16);
		ty = $signed({9'b0, sy_s1, 1'b0}) - 27'sd32768 + $signed(27'(row_s1) << 16);
	end

	// stage 3: anchor scaling and threshold
	logic               v_s3, pass_s3;
	logic signed [23:0] cx_s3, cy_s3;
	logic [15:0]        hw_s3, hh_s3;
	logic [16:0]        prob_s3;
	logic [1:0]         id_s3;

	logic [42:0] pw, ph;
	always_comb begin
		pw = 43'(sqw_s2) * 43'(aw_s2);
		ph = 43'(sqh_s2) * 43'(ah_s2);
	end

	// stage 4 combinational: edges and frame test
	logic signed [23:0] l, t, r, b;
	logic               outside;
	always_comb begin
		l = cx_s3 - $signed({8'b0, hw_s3});
		r = cx_s3 + $signed({8'b0, hw_s3});
		t = cy_s3 - $signed({8'b0, hh_s3});
		b = cy_s3 + $signed({8'b0, hh_s3});
		outside = (r <= 24'sd0) || (b <= 24'sd0) ||
			(l >= $signed({8'b0, fw_q, 4'b0})) || (t >= $signed({8'b0, fh_q, 4'b0}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3 && pass_s3 && !outside;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1   <= sx;
			sy_s1   <= sy;
			sw_s1   <= sw;
			sh_s1   <= sh;
			so_s1   <= so;
			sc_s1   <= sc;
			id_s1   <= best_id;
			head_s1 <= head_index;
			anc_s1  <= (anchor_index > LAST_ANCHOR) ? LAST_ANCHOR : anchor_index;
			col_s1  <= col_c;
			row_s1  <= row_c;

			prob_s2 <= prod[32:16];
			sqw_s2  <= 33'(34'(sw_s1) * 34'(sw_s1));
			sqh_s2  <= 33'(34'(sh_s1) * 34'(sh_s1));
			cx_s2   <= 24'(tx >>> (4'd9 - {2'b0, head_s1}));
			cy_s2   <= 24'(ty >>> (4'd9 - {2'b0, head_s1}));
			aw_s2   <= ANCHOR_W[head_s1][anc_s1];
			ah_s2   <= ANCHOR_H[head_s1][anc_s1];
			id_s2   <= id_s1;

			pass_s3 <= prob_s2 >= {1'b0, thr_q};
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			hw_s3   <= pw[42:27];
			hh_s3   <= ph[42:27];
			prob_s3 <= prob_s2;
			id_s3   <= id_s2;

			box_left   <= l[18:0];
			box_top    <= t[18:0];
			box_right  <= r[18:0];
			box_bottom <= b[18:0];
			top_class  <= id_s3;
			score      <= prob_s3[16] ? 16'hFFFF : prob_s3[15:0];
		end
	end

endmodule

@@ rtl/yabd_checker.sv @@
// Port-level checks for the anchor box decode block, bound to the top level.
// Depends on yolo_anchor_box_decode_unit.
`timescale 1ns / 1ps
module yabd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [18:0] box_left,
	input logic signed [18:0] box_top,
	input logic signed [18:0] box_right,
	input logic signed [18:0] box_bottom,
	input logic [1:0]         top_class
);

	// a held result must stay up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// pipeline freezes with the output
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output held");

	// half sizes are never negative
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> box_right >= box_left && box_bottom >= box_top)
		else $error("box edges out of order");

	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> top_class != 2'd3)
		else $error("bad class");

endmodule

bind yolo_anchor_box_decode_unit yabd_checker u_yabd_checker (.*);
